@@ src/video_io_register_block_core_defines.svh @@
// Assertion macros used by the checker of the video I/O register block.
// No dependencies.
`ifndef VIDEO_IO_REGISTER_BLOCK_CORE_DEFINES_SVH
`define VIDEO_IO_REGISTER_BLOCK_CORE_DEFINES_SVH

// Antecedent implies consequent in the same cycle, ignored during reset.
`define VIO_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Antecedent implies consequent in the next cycle, ignored during reset.
`define VIO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Implication checked in every cycle, reset included.
`define VIO_ASSERT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

@@ src/vio_pkg.sv @@
// Types, constants and register map of the video I/O register block.
// No dependencies.
package vio_pkg;

   localparam int VRAM_DEPTH   = 16384;  // powers of two only
   localparam int SAVE_DEPTH   = 8192;
   localparam int EEPROM_DEPTH = 4096;

   localparam int VRAM_AW   = $clog2(VRAM_DEPTH);
   localparam int SAVE_AW   = $clog2(SAVE_DEPTH);
   localparam int EEPROM_AW = $clog2(EEPROM_DEPTH);

   localparam int CLEAR_LEN = (SAVE_DEPTH > EEPROM_DEPTH) ? SAVE_DEPTH : EEPROM_DEPTH;
   localparam int CLEAR_W   = $clog2(CLEAR_LEN);

   localparam logic [1:0] MODE_READ  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_TICK  = 2'd2;

   localparam logic [2:0] CSR_SAVE_READ_CODE  = 3'd0;
   localparam logic [2:0] CSR_SAVE_WRITE_CODE = 3'd1;
   localparam logic [2:0] CSR_DOTS_PER_LINE   = 3'd2;
   localparam logic [2:0] CSR_LINES_PER_FRAME = 3'd3;
   localparam logic [2:0] CSR_VISIBLE_LINES   = 3'd4;

   localparam logic [15:0] ADDR_CONTROL      = 16'hFE00;
   localparam logic [15:0] ADDR_STATUS       = 16'hFE01;
   localparam logic [15:0] ADDR_SCROLL_X     = 16'hFE02;
   localparam logic [15:0] ADDR_SCROLL_Y     = 16'hFE03;
   localparam logic [15:0] ADDR_RASTER_Y     = 16'hFE04;
   localparam logic [15:0] ADDR_RASTER_CTRL  = 16'hFE05;
   localparam logic [15:0] ADDR_CAMERA_X     = 16'hFE06;
   localparam logic [15:0] ADDR_CAMERA_Y     = 16'hFE07;
   localparam logic [15:0] ADDR_PAL_INDEX    = 16'hFE08;
   localparam logic [15:0] ADDR_PAL_DATA     = 16'hFE09;
   localparam logic [15:0] ADDR_VRAM_LO      = 16'hFE10;
   localparam logic [15:0] ADDR_VRAM_HI      = 16'hFE11;
   localparam logic [15:0] ADDR_VRAM_DATA    = 16'hFE12;
   localparam logic [15:0] ADDR_OAM_PTR      = 16'hFE20;
   localparam logic [15:0] ADDR_OAM_DATA     = 16'hFE21;
   localparam logic [15:0] ADDR_SAVE_CMD     = 16'hFE22;
   localparam logic [15:0] ADDR_SAVE_PTR     = 16'hFE23;
   localparam logic [15:0] ADDR_SAVE_DATA    = 16'hFE24;
   localparam logic [15:0] ADDR_WORLD        = 16'hFE30;
   localparam logic [15:0] ADDR_BANK_FIRST   = 16'hFE31;
   localparam logic [15:0] ADDR_BANK_LAST    = 16'hFE37;
   localparam logic [15:0] ADDR_PAL_ROW      = 16'hFE38;
   localparam logic [15:0] ADDR_SOUND_FIRST  = 16'hFE40;
   localparam logic [15:0] ADDR_SOUND_LAST   = 16'hFE5F;
   localparam logic [15:0] ADDR_PAD_ZERO     = 16'hFE60;
   localparam logic [15:0] ADDR_PAD_ONE      = 16'hFE61;
   localparam logic [15:0] ADDR_EEPROM_LO    = 16'hFE70;
   localparam logic [15:0] ADDR_EEPROM_HI    = 16'hFE71;
   localparam logic [15:0] ADDR_EEPROM_DATA  = 16'hFE72;

   localparam logic [7:0] SCROLL_Y_LIMIT = 8'd120;
   localparam logic [7:0] SCROLL_Y_MAX   = 8'd119;

   typedef enum logic [2:0] {
      SRC_REG,
      SRC_VRAM,
      SRC_SPRITE,
      SRC_SAVE,
      SRC_EEPROM
   } rd_src_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] addr;
      logic [7:0]  wdata;
      logic [7:0]  pad_zero;
      logic [7:0]  pad_one;
   } req_type;

   typedef struct packed {
      logic [7:0] rdata;
      logic       nmi_request;
      logic       bg_camera_update;
   } rsp_type;

   typedef struct packed {
      logic vblank_set;
      logic vblank_clear;
   } raster_evt_type;

endpackage

@@ src/vio_raster.sv @@
// Dot and line raster counter with vertical blank events.
// Depends on vio_pkg.
module vio_raster (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    tick,
   input  logic [9:0]              dots_per_line,
   input  logic [9:0]              lines_per_frame,
   input  logic [9:0]              visible_lines,
   output vio_pkg::raster_evt_type evt
);
   import vio_pkg::*;

   logic [9:0]  col_ff, col_in;
   logic [9:0]  row_ff, row_in;
   logic [10:0] col_inc;
   logic [10:0] row_inc;

   always_comb begin
      col_inc = {1'b0, col_ff} + 11'd1;
      row_inc = {1'b0, row_ff} + 11'd1;
      col_in = col_ff;
      row_in = row_ff;
      evt = '0;
      if (tick) begin
         if (col_inc >= {1'b0, dots_per_line}) begin
            col_in = '0;
            if (row_inc >= {1'b0, lines_per_frame}) begin
               row_in = '0;
            end else begin
               row_in = row_inc[9:0];
            end
            evt.vblank_set = (row_in == visible_lines);
         end else begin
            col_in = col_inc[9:0];
         end
         evt.vblank_clear = (row_in == '0) && (col_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

@@ src/video_io_register_block_core.sv @@
// Top level of the video I/O register block: register map, data ports and stores.
// Depends on vio_pkg and vio_raster.
//
// Each transfer on req is a bus read, a bus write, one dot tick or a no-op and yields
// exactly one transfer on rsp. One item is taken per cycle while req_ready is
// high: its register and store updates happen at the accepting edge and its
// result lands in a single output register, whose store read data comes from
// registered memory ports. req_ready is high whenever the output register is
// empty or being drained. After reset the save and EEPROM stores are cleared
// one entry per cycle, which keeps req_ready low until all 8192 entries of the
// larger store are cleared; CSR writes are taken during that time.
module video_io_register_block_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  vio_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output vio_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [9:0]       csr_wdata
);
   import vio_pkg::*;

   logic [7:0] read_code_ff, write_code_ff;
   logic [9:0] dots_ff, lines_ff, visible_ff;

   logic                 clearing_ff;
   logic [CLEAR_W-1:0]   clear_cnt_ff;

   logic       nmi_en_ff, nmi_en_in;
   logic       vblank_ff, vblank_in;
   logic [7:0] scroll_ff [6];
   logic [7:0] scroll_in [6];
   logic [4:0] pal_idx_ff, pal_idx_in;
   logic [5:0] pal_ff [32];
   logic [VRAM_AW-1:0] vram_ptr_ff, vram_ptr_in;
   logic [7:0]  oam_ptr_ff, oam_ptr_in;
   logic [7:0]  save_cmd_ff, save_cmd_in;
   logic [15:0] save_ptr_ff, save_ptr_in;
   logic [15:0] ee_ptr_ff, ee_ptr_in;
   logic [2:0]  world_ff, world_in, row_ff, row_in;
   logic [7:0]  sound_ff [32];
   logic [7:0]  bank_ff [7];
   logic [255:0] oam_valid_ff;

   logic [7:0] vram_mem [VRAM_DEPTH];
   logic [7:0] oam_mem [256];
   logic [7:0] save_mem [SAVE_DEPTH];
   logic [7:0] ee_mem [EEPROM_DEPTH];
   logic [7:0] vram_q_ff, oam_q_ff, save_q_ff, ee_q_ff;
   logic       oam_qv_ff;

   logic       rsp_valid_ff;
   logic [7:0] rdata_ff, rdata_in;
   logic       nmi_ff, cam_ff, cam_in;
   rd_src_type src_ff, src_in;

   logic       accept, is_read, is_bus_wr, is_tick;
   logic       pal_we, vram_we, oam_we, save_we, ee_we, sound_we, bank_we;
   logic [4:0] sound_idx;
   logic [2:0] bank_idx;
   logic       in_sound, in_bank;
   logic [15:0] vram_ptr16;
   logic [SAVE_AW-1:0]   save_idx;
   logic [EEPROM_AW-1:0] ee_idx;
   logic [7:0] wd, y_clamped;
   raster_evt_type evt;

   assign req_ready = !clearing_ff && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign is_read   = accept && (req_data.mode == MODE_READ);
   assign is_bus_wr = accept && (req_data.mode == MODE_WRITE);
   assign is_tick   = accept && (req_data.mode == MODE_TICK);
   assign wd        = req_data.wdata;
   assign y_clamped = (wd < SCROLL_Y_LIMIT) ? wd : SCROLL_Y_MAX;
   assign in_sound  = (req_data.addr >= ADDR_SOUND_FIRST) && (req_data.addr <= ADDR_SOUND_LAST);
   assign in_bank   = (req_data.addr >= ADDR_BANK_FIRST) && (req_data.addr <= ADDR_BANK_LAST);
   assign sound_idx = 5'(req_data.addr - ADDR_SOUND_FIRST);
   assign bank_idx  = 3'(req_data.addr - ADDR_BANK_FIRST);
   assign vram_ptr16 = 16'(vram_ptr_ff);
   assign save_idx  = save_ptr_ff[SAVE_AW-1:0];
   assign ee_idx    = ee_ptr_ff[EEPROM_AW-1:0];

   vio_raster u_raster (
      .clock           (clock),
      .reset           (reset),
      .tick            (is_tick),
      .dots_per_line   (dots_ff),
      .lines_per_frame (lines_ff),
      .visible_lines   (visible_ff),
      .evt             (evt)
   );

   always_comb begin
      nmi_en_in   = nmi_en_ff;
      vblank_in   = vblank_ff;
      scroll_in   = scroll_ff;
      pal_idx_in  = pal_idx_ff;
      vram_ptr_in = vram_ptr_ff;
      oam_ptr_in  = oam_ptr_ff;
      save_cmd_in = save_cmd_ff;
      save_ptr_in = save_ptr_ff;
      ee_ptr_in   = ee_ptr_ff;
      world_in    = world_ff;
      row_in      = row_ff;
      rdata_in    = '0;
      cam_in      = 1'b0;
      src_in      = SRC_REG;
      pal_we      = 1'b0;
      vram_we     = 1'b0;
      oam_we      = 1'b0;
      save_we     = 1'b0;
      ee_we       = 1'b0;
      sound_we    = 1'b0;
      bank_we     = 1'b0;
      if (is_read) begin
         unique case (req_data.addr)
            ADDR_STATUS: begin
               rdata_in  = {vblank_ff, 7'd0};
               vblank_in = 1'b0;
            end
            ADDR_SCROLL_X:    rdata_in = scroll_ff[0];
            ADDR_SCROLL_Y:    rdata_in = scroll_ff[1];
            ADDR_RASTER_Y:    rdata_in = scroll_ff[2];
            ADDR_RASTER_CTRL: rdata_in = scroll_ff[3];
            ADDR_CAMERA_X:    rdata_in = scroll_ff[4];
            ADDR_CAMERA_Y:    rdata_in = scroll_ff[5];
            ADDR_PAL_DATA: begin
               rdata_in   = {2'b00, pal_ff[pal_idx_ff]};
               pal_idx_in = pal_idx_ff + 5'd1;
            end
            ADDR_VRAM_DATA: begin
               src_in      = SRC_VRAM;
               vram_ptr_in = vram_ptr_ff + VRAM_AW'(1);
            end
            ADDR_OAM_DATA: begin
               src_in     = SRC_SPRITE;
               oam_ptr_in = oam_ptr_ff + 8'd1;
            end
            ADDR_SAVE_CMD: rdata_in = save_cmd_ff;
            ADDR_SAVE_PTR: rdata_in = save_ptr_ff[7:0];
            ADDR_SAVE_DATA: begin
               if (save_cmd_ff == read_code_ff) begin
                  src_in = SRC_SAVE;
               end
            end
            ADDR_WORLD:       rdata_in = {5'd0, world_ff};
            ADDR_PAL_ROW:     rdata_in = {5'd0, row_ff};
            ADDR_PAD_ZERO:    rdata_in = req_data.pad_zero;
            ADDR_PAD_ONE:     rdata_in = req_data.pad_one;
            ADDR_EEPROM_LO:   rdata_in = ee_ptr_ff[7:0];
            ADDR_EEPROM_HI:   rdata_in = ee_ptr_ff[15:8];
            ADDR_EEPROM_DATA: src_in = SRC_EEPROM;
            default: begin
               if (in_sound) begin
                  rdata_in = sound_ff[sound_idx];
               end else if (in_bank) begin
                  rdata_in = bank_ff[bank_idx];
               end
            end
         endcase
      end else if (is_bus_wr) begin
         unique case (req_data.addr)
            ADDR_CONTROL:     nmi_en_in = wd[7];
            ADDR_SCROLL_X:    scroll_in[0] = {1'b0, wd[6:0]};
            ADDR_SCROLL_Y:    scroll_in[1] = y_clamped;
            ADDR_RASTER_Y:    scroll_in[2] = wd;
            ADDR_RASTER_CTRL: scroll_in[3] = wd;
            ADDR_CAMERA_X: begin
               scroll_in[4] = {1'b0, wd[6:0]};
               cam_in       = 1'b1;
            end
            ADDR_CAMERA_Y: begin
               scroll_in[5] = y_clamped;
               cam_in       = 1'b1;
            end
            ADDR_PAL_INDEX: pal_idx_in = wd[4:0];
            ADDR_PAL_DATA: begin
               pal_we     = 1'b1;
               pal_idx_in = pal_idx_ff + 5'd1;
            end
            ADDR_VRAM_LO: vram_ptr_in = VRAM_AW'({vram_ptr16[15:8], wd});
            ADDR_VRAM_HI: vram_ptr_in = VRAM_AW'({wd, vram_ptr16[7:0]});
            ADDR_VRAM_DATA: begin
               vram_we     = 1'b1;
               vram_ptr_in = vram_ptr_ff + VRAM_AW'(1);
            end
            ADDR_OAM_PTR: oam_ptr_in = wd;
            ADDR_OAM_DATA: begin
               oam_we     = 1'b1;
               oam_ptr_in = oam_ptr_ff + 8'd1;
            end
            ADDR_SAVE_CMD: begin
               save_cmd_in = wd;
               if (wd != read_code_ff && wd != write_code_ff) begin
                  save_ptr_in[15:8] = wd;
               end
            end
            ADDR_SAVE_PTR:    save_ptr_in[7:0] = wd;
            ADDR_SAVE_DATA:   save_we = (save_cmd_ff == write_code_ff);
            ADDR_WORLD:       world_in = wd[2:0];
            ADDR_PAL_ROW:     row_in = wd[2:0];
            ADDR_EEPROM_LO:   ee_ptr_in[7:0] = wd;
            ADDR_EEPROM_HI:   ee_ptr_in[15:8] = wd;
            ADDR_EEPROM_DATA: ee_we = 1'b1;
            default: begin
               sound_we = in_sound;
               bank_we  = in_bank && !in_sound;
            end
         endcase
      end else if (is_tick) begin
         if (evt.vblank_set) begin
            vblank_in = 1'b1;
         end
         if (evt.vblank_clear) begin
            vblank_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_code_ff  <= 8'd254;
         write_code_ff <= 8'd255;
         dots_ff       <= 10'd256;
         lines_ff      <= 10'd150;
         visible_ff    <= 10'd120;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SAVE_READ_CODE:  read_code_ff  <= csr_wdata[7:0];
            CSR_SAVE_WRITE_CODE: write_code_ff <= csr_wdata[7:0];
            CSR_DOTS_PER_LINE:   dots_ff       <= csr_wdata;
            CSR_LINES_PER_FRAME: lines_ff      <= csr_wdata;
            CSR_VISIBLE_LINES:   visible_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clear_cnt_ff <= '0;
      end else if (clearing_ff) begin
         clear_cnt_ff <= clear_cnt_ff + CLEAR_W'(1);
         if (clear_cnt_ff == CLEAR_W'(CLEAR_LEN - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nmi_en_ff    <= 1'b0;
         vblank_ff    <= 1'b0;
         scroll_ff    <= '{default: '0};
         pal_idx_ff   <= '0;
         pal_ff       <= '{default: '0};
         vram_ptr_ff  <= '0;
         oam_ptr_ff   <= '0;
         save_cmd_ff  <= '0;
         save_ptr_ff  <= '0;
         ee_ptr_ff    <= '0;
         world_ff     <= '0;
         row_ff       <= '0;
         sound_ff     <= '{default: '0};
         bank_ff      <= '{default: '0};
         oam_valid_ff <= '0;
      end else begin
         nmi_en_ff   <= nmi_en_in;
         vblank_ff   <= vblank_in;
         scroll_ff   <= scroll_in;
         pal_idx_ff  <= pal_idx_in;
         vram_ptr_ff <= vram_ptr_in;
         oam_ptr_ff  <= oam_ptr_in;
         save_cmd_ff <= save_cmd_in;
         save_ptr_ff <= save_ptr_in;
         ee_ptr_ff   <= ee_ptr_in;
         world_ff    <= world_in;
         row_ff      <= row_in;
         if (pal_we) begin
            pal_ff[pal_idx_ff] <= wd[5:0];
         end
         if (sound_we) begin
            sound_ff[sound_idx] <= wd;
         end
         if (bank_we) begin
            bank_ff[bank_idx] <= wd;
         end
         if (oam_we) begin
            oam_valid_ff[oam_ptr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (vram_we) begin
         vram_mem[vram_ptr_ff] <= wd;
      end
      if (is_read) begin
         vram_q_ff <= vram_mem[vram_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (oam_we) begin
         oam_mem[oam_ptr_ff] <= wd;
      end
      if (is_read) begin
         oam_q_ff  <= oam_mem[oam_ptr_ff];
         oam_qv_ff <= oam_valid_ff[oam_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         save_mem[clear_cnt_ff[SAVE_AW-1:0]] <= '0;
      end else if (save_we) begin
         save_mem[save_idx] <= wd;
      end
      if (is_read) begin
         save_q_ff <= save_mem[save_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         ee_mem[clear_cnt_ff[EEPROM_AW-1:0]] <= '0;
      end else if (ee_we) begin
         ee_mem[ee_idx] <= wd;
      end
      if (is_read) begin
         ee_q_ff <= ee_mem[ee_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rdata_ff <= rdata_in;
         nmi_ff   <= is_tick && evt.vblank_set && nmi_en_ff;
         cam_ff   <= cam_in;
         src_ff   <= src_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data.nmi_request      = nmi_ff;
   assign rsp_data.bg_camera_update = cam_ff;

   always_comb begin
      unique case (src_ff)
         SRC_VRAM:   rsp_data.rdata = vram_q_ff;
         SRC_SPRITE: rsp_data.rdata = oam_qv_ff ? oam_q_ff : 8'hFF;
         SRC_SAVE:   rsp_data.rdata = save_q_ff;
         SRC_EEPROM: rsp_data.rdata = ee_q_ff;
         default:    rsp_data.rdata = rdata_ff;
      endcase
   end

endmodule

@@ src/vio_checker.sv @@
// Port-level checks of the video I/O register block, bound to its top level.
// Depends on vio_pkg and the assertion macros header.
`include "video_io_register_block_core_defines.svh"

module vio_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input vio_pkg::rsp_type rsp_data
);
   import vio_pkg::*;

   // A stalled result keeps its transfer pending and its payload unchanged.
   `VIO_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // A result that requests an NMI comes from a tick and so carries neither read data nor a camera update.
   `VIO_ASSERT_SAME(a_rsp_excl, clock, reset, rsp_valid && rsp_data.nmi_request,
      rsp_data.rdata == 8'd0 && !rsp_data.bg_camera_update)

   // Right after reset the stores are being cleared and nothing is pending.
   `VIO_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset), !req_ready && !rsp_valid)

   // A full output register that is not drained blocks new requests.
   `VIO_ASSERT_SAME(a_backpressure, clock, reset, rsp_valid && !rsp_ready, !req_ready)

   // Every request transfer puts a result on rsp in the next cycle.
   `VIO_ASSERT_NEXT(a_rsp_follows, clock, reset, req_valid && req_ready, rsp_valid)

endmodule

bind video_io_register_block_core vio_checker u_vio_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

@@ tb/tb_video_io_register_block_core.sv @@
// Self-checking testbench of the video I/O register block core.
// Depends on vio_pkg and video_io_register_block_core; predicts each response
// from its own copy of the register state and compares every transfer on rsp.
`timescale 1ns / 1ps

module tb_video_io_register_block_core;
   import vio_pkg::*;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [9:0] csr_wdata = '0;

   video_io_register_block_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow state of the block.
   int         read_code, write_code, dots_line, lines_frame, vis_lines;
   logic [7:0] ctl, stat, world, pal_row, save_cmd;
   logic [7:0] scroll [6];
   logic [7:0] pal [32];
   logic [7:0] vram [VRAM_DEPTH];
   bit         vram_set [VRAM_DEPTH];
   logic [7:0] oam [256];
   logic [7:0] save_mem [SAVE_DEPTH];
   logic [7:0] ee_mem [EEPROM_DEPTH];
   logic [7:0] sound [32];
   logic [7:0] bank [7];
   int         pal_idx, vram_ptr, oam_ptr, save_ptr, ee_ptr, dot_col, dot_line;

   rsp_type    pending_rsp [$];
   int         mismatches = 0;
   int         hold_cycles = 0;
   bit         no_gaps = 1'b0;

   task automatic shadow_reset();
      read_code = 254; write_code = 255;
      dots_line = 256; lines_frame = 150; vis_lines = 120;
      ctl = 8'h02; stat = 0; world = 0; pal_row = 0; save_cmd = 0;
      foreach (scroll[i]) scroll[i] = 0;
      foreach (pal[i]) pal[i] = 0;
      foreach (vram_set[i]) vram_set[i] = 0;
      foreach (oam[i]) oam[i] = 8'hFF;
      foreach (save_mem[i]) save_mem[i] = 0;
      foreach (ee_mem[i]) ee_mem[i] = 0;
      foreach (sound[i]) sound[i] = 0;
      foreach (bank[i]) bank[i] = 0;
      pal_idx = 0; vram_ptr = 0; oam_ptr = 0; save_ptr = 0; ee_ptr = 0;
      dot_col = 0; dot_line = 0;
   endtask

   function automatic int ee_slot();
      return ((((ee_ptr >> 8) & 15) << 8) | (ee_ptr & 255)) % EEPROM_DEPTH;
   endfunction

   function automatic rsp_type predict_access(req_type r);
      rsp_type o;
      int      a, v;
      o = '0;
      a = r.addr;
      v = r.wdata;
      if (r.mode == MODE_READ) begin
         if (a == ADDR_STATUS) begin
            o.rdata = stat;
            stat = stat & 8'h3F;
         end else if (a >= ADDR_SCROLL_X && a <= ADDR_CAMERA_Y) begin
            o.rdata = scroll[a - ADDR_SCROLL_X];
         end else if (a == ADDR_PAL_DATA) begin
            o.rdata = pal[pal_idx];
            pal_idx = (pal_idx + 1) & 31;
         end else if (a == ADDR_VRAM_DATA) begin
            o.rdata = vram[vram_ptr];
            vram_ptr = (vram_ptr + 1) % VRAM_DEPTH;
         end else if (a == ADDR_OAM_DATA) begin
            o.rdata = oam[oam_ptr];
            oam_ptr = (oam_ptr + 1) & 255;
         end else if (a == ADDR_SAVE_CMD) o.rdata = save_cmd;
         else if (a == ADDR_SAVE_PTR) o.rdata = save_ptr & 255;
         else if (a == ADDR_SAVE_DATA)
            o.rdata = (save_cmd == read_code) ? save_mem[save_ptr % SAVE_DEPTH] : 8'h00;
         else if (a == ADDR_WORLD) o.rdata = world;
         else if (a == ADDR_PAL_ROW) o.rdata = pal_row;
         else if (a == ADDR_PAD_ZERO) o.rdata = r.pad_zero;
         else if (a == ADDR_PAD_ONE) o.rdata = r.pad_one;
         else if (a == ADDR_EEPROM_LO) o.rdata = ee_ptr & 255;
         else if (a == ADDR_EEPROM_HI) o.rdata = (ee_ptr >> 8) & 255;
         else if (a == ADDR_EEPROM_DATA) o.rdata = ee_mem[ee_slot()];
         else if (a >= ADDR_SOUND_FIRST && a <= ADDR_SOUND_LAST)
            o.rdata = sound[a - ADDR_SOUND_FIRST];
         else if (a >= ADDR_BANK_FIRST && a <= ADDR_BANK_LAST)
            o.rdata = bank[a - ADDR_BANK_FIRST];
      end else if (r.mode == MODE_WRITE) begin
         case (a)
            ADDR_CONTROL: ctl = v;
            ADDR_SCROLL_X: scroll[0] = v & 127;
            ADDR_SCROLL_Y: scroll[1] = (v < SCROLL_Y_LIMIT) ? v : SCROLL_Y_MAX;
            ADDR_RASTER_Y: scroll[2] = v;
            ADDR_RASTER_CTRL: scroll[3] = v;
            ADDR_CAMERA_X: begin
               scroll[4] = v & 127;
               o.bg_camera_update = 1'b1;
            end
            ADDR_CAMERA_Y: begin
               scroll[5] = (v < SCROLL_Y_LIMIT) ? v : SCROLL_Y_MAX;
               o.bg_camera_update = 1'b1;
            end
            ADDR_PAL_INDEX: pal_idx = v & 31;
            ADDR_PAL_DATA: begin
               pal[pal_idx] = v & 63;
               pal_idx = (pal_idx + 1) & 31;
            end
            ADDR_VRAM_LO: vram_ptr = ((vram_ptr & 'hFF00) | v) % VRAM_DEPTH;
            ADDR_VRAM_HI: vram_ptr = ((vram_ptr & 'hFF) | (v << 8)) % VRAM_DEPTH;
            ADDR_VRAM_DATA: begin
               vram[vram_ptr] = v;
               vram_set[vram_ptr] = 1'b1;
               vram_ptr = (vram_ptr + 1) % VRAM_DEPTH;
            end
            ADDR_OAM_PTR: oam_ptr = v;
            ADDR_OAM_DATA: begin
               oam[oam_ptr] = v;
               oam_ptr = (oam_ptr + 1) & 255;
            end
            ADDR_SAVE_CMD: begin
               save_cmd = v;
               if (v != read_code && v != write_code)
                  save_ptr = (save_ptr & 'hFF) | (v << 8);
            end
            ADDR_SAVE_PTR: save_ptr = (save_ptr & 'hFF00) | v;
            ADDR_SAVE_DATA: if (save_cmd == write_code) save_mem[save_ptr % SAVE_DEPTH] = v;
            ADDR_WORLD: world = v & 7;
            ADDR_PAL_ROW: pal_row = v & 7;
            ADDR_EEPROM_LO: ee_ptr = (ee_ptr & 'hFF00) | v;
            ADDR_EEPROM_HI: ee_ptr = (ee_ptr & 'hFF) | (v << 8);
            ADDR_EEPROM_DATA: ee_mem[ee_slot()] = v;
            default: begin
               if (a >= ADDR_SOUND_FIRST && a <= ADDR_SOUND_LAST)
                  sound[a - ADDR_SOUND_FIRST] = v;
               else if (a >= ADDR_BANK_FIRST && a <= ADDR_BANK_LAST)
                  bank[a - ADDR_BANK_FIRST] = v;
            end
         endcase
      end else if (r.mode == MODE_TICK) begin
         dot_col = (dot_col + 1) & 'h7FF;
         if (dot_col >= dots_line) begin
            dot_col = 0;
            dot_line = (dot_line + 1) & 'h7FF;
            if (dot_line >= lines_frame) dot_line = 0;
            if (dot_line == vis_lines) begin
               stat = stat | 8'h80;
               if (ctl[7]) o.nmi_request = 1'b1;
            end
         end
         if (dot_line == 0 && dot_col == 0) stat = stat & 8'h7F;
      end
      return o;
   endfunction

   task automatic send_item(req_type r);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      // A VRAM read of an entry never written is turned into a write.
      if (r.mode == MODE_READ && r.addr == ADDR_VRAM_DATA && !vram_set[vram_ptr])
         r.mode = MODE_WRITE;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      pending_rsp.push_back(predict_access(r));
   endtask

   task automatic send_op(logic [1:0] m, logic [15:0] a, logic [7:0] d);
      req_type r;
      r.mode = m;
      r.addr = a;
      r.wdata = d;
      r.pad_zero = $urandom;
      r.pad_one = $urandom;
      send_item(r);
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, int val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_SAVE_READ_CODE: read_code = val & 255;
         CSR_SAVE_WRITE_CODE: write_code = val & 255;
         CSR_DOTS_PER_LINE: dots_line = val & 1023;
         CSR_LINES_PER_FRAME: lines_frame = val & 1023;
         default: vis_lines = val & 1023;
      endcase
   endtask

   task automatic set_geometry(int dpl, int lpf, int vis);
      drain_all();
      csr_write(CSR_DOTS_PER_LINE, dpl);
      csr_write(CSR_LINES_PER_FRAME, lpf);
      csr_write(CSR_VISIBLE_LINES, vis);
   endtask

   function automatic logic [15:0] pick_addr();
      case ($urandom_range(0, 13))
         0: return $urandom;
         1: return ADDR_CONTROL + $urandom_range(0, 9);
         2: return ADDR_VRAM_LO + $urandom_range(0, 2);
         3: return ADDR_OAM_PTR + $urandom_range(0, 4);
         4: return ADDR_WORLD + $urandom_range(0, 8);
         5: return ADDR_SOUND_FIRST + $urandom_range(0, 31);
         6: return ADDR_PAD_ZERO + $urandom_range(0, 1);
         7: return ADDR_EEPROM_LO + $urandom_range(0, 2);
         8: return 16'hFE90 + $urandom_range(0, 3);
         default: return ADDR_STATUS;
      endcase
   endfunction

   task automatic test_directed();
      send_op(MODE_READ, ADDR_STATUS, 0);
      send_op(MODE_READ, ADDR_OAM_DATA, 0);
      send_op(MODE_WRITE, ADDR_SCROLL_X, 8'hFF);
      send_op(MODE_WRITE, ADDR_SCROLL_Y, 8'd120);
      send_op(MODE_WRITE, ADDR_CAMERA_X, 8'hFF);
      send_op(MODE_WRITE, ADDR_CAMERA_Y, 8'd119);
      send_op(MODE_READ, ADDR_SCROLL_Y, 0);
      send_op(MODE_READ, ADDR_CAMERA_X, 0);
      send_op(MODE_WRITE, ADDR_PAL_INDEX, 8'hFF);
      send_op(MODE_WRITE, ADDR_PAL_DATA, 8'hFF);
      send_op(MODE_READ, ADDR_PAL_DATA, 0);
      send_op(MODE_WRITE, ADDR_VRAM_HI, 8'hFF);
      send_op(MODE_WRITE, ADDR_VRAM_DATA, 8'h5A);
      send_op(MODE_WRITE, ADDR_SAVE_CMD, 8'hFF);
      send_op(MODE_WRITE, ADDR_SAVE_DATA, 8'hA5);
      send_op(MODE_WRITE, ADDR_SAVE_CMD, 8'hFE);
      send_op(MODE_READ, ADDR_SAVE_DATA, 0);
      send_op(MODE_WRITE, ADDR_EEPROM_HI, 8'hFF);
      send_op(MODE_WRITE, ADDR_EEPROM_DATA, 8'h00);
      send_op(MODE_READ, ADDR_EEPROM_HI, 0);
      send_op(MODE_WRITE, 16'hFFFF, 8'hFF);
      send_op(MODE_READ, 16'h0000, 0);
      send_op(MODE_WRITE, ADDR_PAD_ZERO, 8'h12);
      send_op(MODE_READ, ADDR_PAD_ONE, 0);
      send_op(2'd3, 16'hFFFF, 8'hFF);
   endtask

   task automatic test_raster();
      send_op(MODE_WRITE, ADDR_CONTROL, 8'h80);
      set_geometry(2, 3, 2);
      repeat (30) send_op(MODE_TICK, $urandom, $urandom);
      send_op(MODE_READ, ADDR_STATUS, 0);
      set_geometry(1, 1, 0);
      repeat (8) send_op(MODE_TICK, 0, 0);
      set_geometry(0, 0, 0);
      repeat (8) send_op(MODE_TICK, 0, 0);
      send_op(MODE_READ, ADDR_STATUS, 0);
      set_geometry(1023, 1023, 1023);
      repeat (20) send_op(MODE_TICK, 0, 0);
      set_geometry(1, 4, 4);
      repeat (12) send_op(MODE_TICK, 0, 0);
   endtask

   task automatic test_random(int count);
      int n;
      n = 0;
      while (n < count) begin
         if (n % 150 == 0) begin
            drain_all();
            csr_write(CSR_SAVE_READ_CODE, ($urandom_range(0, 3) == 0) ? 0 : $urandom);
            csr_write(CSR_SAVE_WRITE_CODE, ($urandom_range(0, 3) == 0) ? 255 : $urandom);
            set_geometry($urandom_range(1, 6), $urandom_range(1, 5), $urandom_range(0, 5));
            no_gaps = ($urandom_range(0, 2) == 0);
         end
         case ($urandom_range(0, 5))
            0: begin
               send_op(MODE_WRITE, ADDR_SAVE_CMD, write_code);
               send_op(MODE_WRITE, ADDR_SAVE_PTR, $urandom);
               send_op(MODE_WRITE, ADDR_SAVE_DATA, $urandom);
               send_op(MODE_WRITE, ADDR_SAVE_CMD, read_code);
               send_op(MODE_READ, ADDR_SAVE_DATA, 0);
               n += 5;
            end
            1: begin
               send_op(MODE_WRITE, ADDR_VRAM_LO, $urandom);
               send_op(MODE_WRITE, ADDR_VRAM_HI, $urandom);
               send_op(MODE_WRITE, ADDR_VRAM_DATA, $urandom);
               send_op(MODE_WRITE, ADDR_VRAM_LO, (vram_ptr - 1) & 255);
               send_op(MODE_READ, ADDR_VRAM_DATA, 0);
               n += 5;
            end
            2: begin
               repeat (4) send_op(MODE_TICK, $urandom, $urandom);
               n += 4;
            end
            default: begin
               send_op($urandom_range(0, 3), pick_addr(), $urandom);
               n += 1;
            end
         endcase
      end
   endtask

   task automatic test_backpressure();
      drain_all();
      no_gaps = 1'b1;
      hold_cycles = 60;
      repeat (30) send_op(MODE_WRITE, ADDR_SOUND_FIRST + $urandom_range(0, 31), $urandom);
      repeat (10) send_op(MODE_READ, ADDR_SOUND_FIRST + $urandom_range(0, 31), 0);
      no_gaps = 1'b0;
      drain_all();
   endtask

   // Response side: random stalls, an optional long hold, one check per transfer.
   initial begin
      rsp_type want;
      int      stall;
      @(negedge reset);
      forever begin
         stall = (hold_cycles > 0) ? hold_cycles : $urandom_range(0, 5);
         hold_cycles = 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transfer on rsp: %p", rsp_data);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.rdata !== want.rdata || rsp_data.nmi_request !== want.nmi_request
                || rsp_data.bg_camera_update !== want.bg_camera_update) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("rsp mismatch: expected %p, got %p", want, rsp_data);
            end
         end
      end
   end

   initial begin
      #3ms;
      $display("tb_video_io_register_block_core failed");
      $finish;
   end

   initial begin
      shadow_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_raster();
      test_backpressure();
      test_random(760);
      drain_all();
      repeat (5) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_video_io_register_block_core passed");
      end else begin
         $display("tb_video_io_register_block_core failed");
      end
      $finish;
   end

endmodule
